// ----- hdl/motor_feedback_kalman_unwrap_assert.svh -----
// Assertion macros for the motor feedback block.
`ifndef MOTOR_FEEDBACK_KALMAN_UNWRAP_ASSERT_SVH
`define MOTOR_FEEDBACK_KALMAN_UNWRAP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MFK_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define MFK_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("%m failed");
`else
`define MFK_ASSERT_IMPL(label, clk, rst_n, prop)
`define MFK_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ----- hdl/mfk_pkg.sv -----
// ----------------------------------------------------------------------------
// mfk_pkg
// Shared types and constants of the motor feedback Kalman block.
// ----------------------------------------------------------------------------
package mfk_pkg;
    localparam int MotorCount  = 7;
    localparam int FilterCount = 10;
    localparam logic [10:0] IdFirst = 11'h201;
    localparam logic [10:0] IdLast  = 11'h207;
    localparam logic [31:0] VarReset = 32'd25600;

    localparam logic [1:0] CFG_DECIM = 2'd0;
    localparam logic [1:0] CFG_QNOISE = 2'd1;
    localparam logic [1:0] CFG_RNOISE = 2'd2;

    // classified request from the front part
    typedef struct packed {
        logic [2:0]         slot;
        logic               gimbal;
        logic               do_step;
        logic [12:0]        angle;
        logic signed [15:0] speed;
    } t_req;

    typedef enum logic [3:0] {
        S_IDLE, S_SPD_LOAD, S_SPD_DIV, S_SPD_MUL, S_SPD_FIN,
        S_UNWRAP, S_STP_LOAD, S_STP_DIV, S_STP_MUL, S_STP_FIN, S_OUT
    } t_state;
endpackage

// ----- hdl/mfk_front.sv -----
// ----------------------------------------------------------------------------
// mfk_front
// Accept frames, drop unknown ids, run the decimation counters, queue work.
// ----------------------------------------------------------------------------
module mfk_front import mfk_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [10:0] i_id,
    input  logic [12:0] i_angle,
    input  logic [15:0] i_speed,
    input  logic [7:0]  i_decim,
    output logic        o_q_valid,
    input  logic        i_q_pop,
    output t_req        o_q_data
);
    logic [7:0] r_cnt [5];
    t_req       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_fill;
    logic       w_acc, w_known, w_push;
    logic [2:0] w_slot, w_cidx;
    logic [7:0] w_cnt_inc;
    t_req       w_req;

    assign o_ready   = (r_fill != 2'd2);
    assign w_acc     = i_valid && o_ready;
    assign w_known   = (i_id >= IdFirst) && (i_id <= IdLast);
    assign w_slot    = 3'(i_id - IdFirst);
    assign w_cidx    = (w_slot == 3'd6) ? 3'd4 : w_slot;
    assign w_cnt_inc = r_cnt[w_cidx] + 8'd1;
    assign w_push    = w_acc && w_known;

    // classify the frame
    always_comb begin
        w_req.slot    = w_slot;
        w_req.gimbal  = (w_slot == 3'd4) || (w_slot == 3'd5);
        w_req.do_step = !w_req.gimbal && (w_cnt_inc == i_decim);
        w_req.angle   = i_angle;
        w_req.speed   = i_speed;
    end

    // advance counters and queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) r_cnt[i] <= '0;
            r_wp <= 1'b0; r_rp <= 1'b0; r_fill <= '0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= w_req;
                r_wp <= ~r_wp;
                if (!w_req.gimbal) r_cnt[w_cidx] <= w_req.do_step ? 8'd0 : w_cnt_inc;
            end
            if (i_q_pop) r_rp <= ~r_rp;
            r_fill <= r_fill + 2'(w_push) - 2'(i_q_pop);
        end
    end

    assign o_q_valid = (r_fill != 2'd0);
    assign o_q_data  = r_q[r_rp];
endmodule

// ----- hdl/mfk_div.sv -----
// ----------------------------------------------------------------------------
// mfk_div
// Restoring divider: 48-bit numerator over 33-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module mfk_div import mfk_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_num,
    input  logic [32:0] i_den,
    output logic        o_done,
    output logic [47:0] o_quo
);
    logic [47:0] r_q;
    logic [33:0] r_rem;
    logic [32:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [33:0] w_sh;

    assign w_sh = {r_rem[32:0], r_q[47]};

    // shift one bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_cnt <= '0;
        end else if (i_start) begin
            r_q <= i_num; r_rem <= '0; r_den <= i_den;
            r_cnt <= 6'd48; r_busy <= 1'b1;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_den}) begin
                r_rem <= w_sh - {1'b0, r_den};
                r_q   <= {r_q[46:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q   <= {r_q[46:0], 1'b0};
            end
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) r_busy <= 1'b0;
        end
    end
    assign o_done = r_busy && (r_cnt == 6'd1);
    assign o_quo  = {r_q[46:0], (w_sh >= {1'b0, r_den})};
endmodule

// ----- hdl/mfk_back.sv -----
// ----------------------------------------------------------------------------
// mfk_back
// Run the Kalman updates, unwrap the step and hold the result.
// ----------------------------------------------------------------------------
module mfk_back import mfk_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    output logic        o_q_pop,
    input  t_req        i_q_data,
    input  logic [15:0] i_qn,
    input  logic [15:0] i_rn,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_slot,
    output logic [15:0] o_speed,
    output logic        o_step_valid,
    output logic [15:0] o_step,
    output logic [12:0] o_angle,
    output logic [15:0] o_current
);
    t_state r_st, n_st;
    t_req   r_req;
    logic signed [31:0] r_est [FilterCount];
    logic [31:0]        r_var [FilterCount];
    logic [12:0]        r_last [MotorCount];
    logic signed [15:0] r_acc [MotorCount];
    logic [3:0]         r_fi;
    logic [31:0]        r_vp;
    logic [16:0]        r_k;
    logic signed [33:0] r_diff;
    logic signed [50:0] r_corr;
    logic [48:0]        r_vk;
    logic signed [15:0] r_spd, r_d;
    logic               r_out_v;
    logic [2:0]         r_o_slot;
    logic [15:0]        r_o_spd, r_o_step, r_o_cur;
    logic               r_o_sv;
    logic [12:0]        r_o_ang;
    logic               w_div_start, w_div_done;
    logic [47:0]        w_quo;
    logic [32:0]        w_vp_sum, w_den;
    logic [31:0]        w_vp;
    logic signed [32:0] w_ne;
    logic signed [31:0] w_ne_sat;
    logic signed [23:0] w_o;
    logic signed [15:0] w_o16;
    logic signed [15:0] w_meas, w_sp0;
    logic signed [16:0] w_d1, w_g;
    logic signed [16:0] w_d2;
    logic [3:0]         w_fspd, w_fstp;

    // speed filter of the request being popped, step filter of the current one
    assign w_fspd = (i_q_data.slot == 3'd6) ? 4'd8 : 4'({1'b0, i_q_data.slot} + 4'd4);
    assign w_fstp = (r_req.slot == 3'd6) ? 4'd9 : {1'b0, r_req.slot};
    // predicted variance, stable from load until the filter finishes
    assign w_vp_sum = {1'b0, r_var[r_fi]} + {9'd0, i_qn, 8'd0};
    assign w_vp  = w_vp_sum[32] ? 32'hFFFF_FFFF : w_vp_sum[31:0];
    assign w_den = {1'b0, w_vp} + {9'd0, i_rn, 8'd0};
    assign w_meas = (r_st == S_STP_LOAD) ? r_d : r_req.speed;
    assign w_div_start = (r_st == S_SPD_LOAD) || (r_st == S_STP_LOAD);

    mfk_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num({w_vp, 16'd0}), .i_den(w_den), .o_done(w_div_done), .o_quo(w_quo)
    );

    // estimate update and output conversion
    assign w_ne = 33'(r_est[r_fi]) + 33'(r_corr >>> 16) +
                  ((r_corr < 0 && r_corr[15:0] != 16'd0) ? 33'sd1 : 33'sd0);
    assign w_ne_sat = (w_ne > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                      (w_ne < -33'sh0_8000_0000) ? 32'sh8000_0000 : w_ne[31:0];
    assign w_o = 24'((w_ne_sat + ((w_ne_sat < 0) ? 32'sd255 : 32'sd0)) >>> 8);
    assign w_o16 = (w_o > 24'sd32767) ? 16'sh7FFF :
                   (w_o < -24'sd32768) ? 16'sh8000 : w_o[15:0];

    // deadband, unwrap and jump guard
    assign w_sp0 = (r_spd < 16'sd5 && r_spd > -16'sd5) ? 16'sd0 : r_spd;
    assign w_d1  = 17'($signed({4'd0, r_req.angle})) -
                   17'($signed({4'd0, r_last[r_req.slot]}));
    always_comb begin
        w_d2 = w_d1;
        if (w_sp0 >= 0 && w_d1 < -17'sd10) w_d2 = w_d1 + 17'sd8192;
        else if (w_sp0 < 0 && w_d1 > 17'sd10) w_d2 = w_d1 - 17'sd8192;
        w_g = w_d2 - 17'(r_acc[r_req.slot]);
    end

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE:     if (i_q_valid && !r_out_v) n_st = i_q_data.gimbal ? S_OUT : S_SPD_LOAD;
            S_SPD_LOAD: n_st = S_SPD_DIV;
            S_SPD_DIV:  if (w_div_done) n_st = S_SPD_MUL;
            S_SPD_MUL:  n_st = S_SPD_FIN;
            S_SPD_FIN:  n_st = r_req.do_step ? S_UNWRAP : S_OUT;
            S_UNWRAP:   n_st = S_STP_LOAD;
            S_STP_LOAD: n_st = S_STP_DIV;
            S_STP_DIV:  if (w_div_done) n_st = S_STP_MUL;
            S_STP_MUL:  n_st = S_STP_FIN;
            S_STP_FIN:  n_st = S_OUT;
            S_OUT:      n_st = S_IDLE;
            default:    n_st = S_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb begin
        o_q_pop = (r_st == S_IDLE) && i_q_valid && !r_out_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_out_v <= 1'b0;
            for (int i = 0; i < FilterCount; i++) begin
                r_est[i] <= '0; r_var[i] <= VarReset;
            end
            for (int i = 0; i < MotorCount; i++) begin
                r_last[i] <= '0; r_acc[i] <= '0;
            end
        end else begin
            r_st <= n_st;
            if (o_valid && i_ready) r_out_v <= 1'b0;
            unique case (r_st)
                S_IDLE: if (o_q_pop) begin
                    r_req <= i_q_data;
                    r_fi <= w_fspd; r_spd <= '0; r_d <= '0;
                end
                S_SPD_LOAD, S_STP_LOAD: begin
                    r_diff <= 34'(w_meas) * 34'sd256 - 34'(r_est[r_fi]);
                    r_vp   <= w_vp;
                end
                S_SPD_DIV, S_STP_DIV: if (w_div_done) begin
                    r_k <= (w_den == '0) ? 17'd0 : w_quo[16:0];
                end
                S_SPD_MUL, S_STP_MUL: begin
                    r_corr <= 51'($signed({1'b0, r_k})) * 51'(r_diff);
                    r_vk   <= 49'(r_vp) * 49'(17'h10000 - r_k);
                end
                S_SPD_FIN, S_STP_FIN: begin
                    r_est[r_fi] <= w_ne_sat;
                    r_var[r_fi] <= r_vk[47:16];
                    if (r_st == S_SPD_FIN) r_spd <= w_o16; else r_d <= w_o16;
                end
                S_UNWRAP: begin
                    r_fi <= w_fstp;
                    r_last[r_req.slot] <= r_req.angle;
                    r_spd <= w_sp0;
                    if (w_g > 17'sd4000) r_d <= 16'(w_d2 - 17'sd8192);
                    else if (w_g < -17'sd4000) r_d <= 16'(w_d2 + 17'sd8192);
                    else begin
                        r_d <= w_d2[15:0]; r_acc[r_req.slot] <= w_d2[15:0];
                    end
                end
                S_OUT: begin
                    r_out_v  <= 1'b1;
                    r_o_slot <= r_req.slot;
                    r_o_spd  <= r_req.gimbal ? 16'd0 : r_spd;
                    r_o_sv   <= r_req.do_step && !r_req.gimbal;
                    r_o_step <= (r_req.do_step && !r_req.gimbal) ? r_d : 16'd0;
                    r_o_ang  <= r_req.gimbal ? r_req.angle : r_last[r_req.slot];
                    r_o_cur  <= r_req.gimbal ? r_req.speed : 16'd0;
                    if (r_req.gimbal) r_last[r_req.slot] <= r_req.angle;
                end
                default: ;
            endcase
        end
    end

    assign o_valid      = r_out_v;
    assign o_slot       = r_o_slot;
    assign o_speed      = r_o_spd;
    assign o_step_valid = r_o_sv;
    assign o_step       = r_o_step;
    assign o_angle      = r_o_ang;
    assign o_current    = r_o_cur;
endmodule

// ----- hdl/motor_feedback_kalman_unwrap.sv -----
// One frame is in work at a time: the back pops the next frame only after
// the last result has been taken. The bit-serial gain divider is used once
// per filter: for the speed filter of a motor frame and, with an angle step,
// for the step filter too; a gimbal frame uses no filter.
// A two-entry queue lets the front keep accepting while the back works.
// Synchronous active-low reset restores all filter state and control registers.
// ----------------------------------------------------------------------------
// motor_feedback_kalman_unwrap
// Motor feedback preprocessor: Kalman speed and unwrapped angle steps.
// ----------------------------------------------------------------------------
`include "motor_feedback_kalman_unwrap_assert.svh"
module motor_feedback_kalman_unwrap import mfk_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // frame_id, angle_raw, speed_raw
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // motor_slot, speed_filtered, step_valid,
                                       // angle_step, angle_now, current_raw
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    logic [7:0]  r_decim;
    logic [15:0] r_qn, r_rn;
    logic        w_qv, w_pop, w_sv;
    t_req        w_qd;
    logic [2:0]  w_slot;
    logic [15:0] w_spd, w_step, w_cur;
    logic [12:0] w_ang;

    // hold configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decim <= 8'd1; r_qn <= 16'd600; r_rn <= 16'd5000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DECIM:  r_decim <= i_cfg_data[7:0];
                CFG_QNOISE: r_qn <= i_cfg_data;
                CFG_RNOISE: r_rn <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mfk_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_id(s_axis_tdata[10:0]), .i_angle(s_axis_tdata[23:11]),
        .i_speed(s_axis_tdata[39:24]), .i_decim(r_decim),
        .o_q_valid(w_qv), .i_q_pop(w_pop), .o_q_data(w_qd)
    );

    mfk_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(w_qv), .o_q_pop(w_pop),
        .i_q_data(w_qd), .i_qn(r_qn), .i_rn(r_rn),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_slot(w_slot),
        .o_speed(w_spd), .o_step_valid(w_sv), .o_step(w_step), .o_angle(w_ang),
        .o_current(w_cur)
    );

    assign m_axis_tdata = {7'd0, w_cur, w_ang, w_step, w_sv, w_spd, w_slot};

    `MFK_ASSERT_IMPL(a_slot_range, i_clk, i_rst_n, m_axis_tvalid |-> (w_slot <= 3'd6))
    `MFK_ASSERT_NEXT(a_hold_out, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `MFK_ASSERT_IMPL(a_step_zero, i_clk, i_rst_n, (m_axis_tvalid && !w_sv) |-> (w_step == 16'd0))
endmodule
